@@ rtl/cslru_pkg.sv @@
// ---------------------------------------------------------------------------
// cslru_pkg
// Types and constants shared by the cursor-shape cache modules.
// ---------------------------------------------------------------------------
package cslru_pkg;

  localparam int KEY_W  = 64;
  localparam int HOT_W  = 16;
  localparam int SIDE_W = 12;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 5;
  localparam int CH_W   = 9;
  localparam int LIM_W  = 6;
  localparam int DEFAULT_LIMIT = 20;

  // cache geometry, tied to the slot and size field widths
  localparam int SLOTS      = 32;
  localparam int MAX_SIDE   = 384;
  localparam int SMALL_SIDE = 96;

  // result select codes
  localparam logic [1:0] SEL_DEFAULT = 2'd0;
  localparam logic [1:0] SEL_NEW     = 2'd1;
  localparam logic [1:0] SEL_CACHED  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEFAULT = 2'd0,
    KIND_SMALL   = 2'd1,
    KIND_LARGE   = 2'd2,
    KIND_CACHED  = 2'd3
  } kind_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef struct packed {
    logic [0:0]              opcode;
    logic signed [KEY_W-1:0] image_key;
    logic signed [HOT_W-1:0] hotspot_x;
    logic signed [HOT_W-1:0] hotspot_y;
    logic [SIDE_W-1:0]       img_width;
    logic [SIDE_W-1:0]       img_height;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_index;
    logic [CH_W-1:0]   clamped_hot_x;
    logic [CH_W-1:0]   clamped_hot_y;
    logic [CH_W-1:0]   out_width;
    logic [CH_W-1:0]   out_height;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic clear;     // empty cache
    logic scan_rst;  // restart scan pointer and results
    logic scan_step; // examine one slot
    logic touch_rst; // restart touch pointer
    logic touch_step;// update one slot's recency
    logic commit;    // write victim entry, count, recent mark
    logic set_recent;// mark hit slot as recent
    logic sel_new;   // target = victim, fresh decision applies
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_empty;
    logic is_big;
    logic recent_hit;
    logic scan_done;
    logic hit;
    logic touch_done;
  } dp_stat_t;

endpackage

@@ rtl/cslru_if.sv @@
// ---------------------------------------------------------------------------
// cslru_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface cslru_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/cursor_shape_lru_cache.sv @@
// ---------------------------------------------------------------------------
// cursor_shape_lru_cache
// Fully associative cursor-shape cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Usage: cursor updates and clear ops arrive on in_ch (valid/ready); pointer
// commands leave on out_ch, last marking the final one of an update. The
// limit register must be written over cfg_ch only while the block is idle;
// the block itself does not enforce this. One item is handled at a time.
// An update scans every slot, one per cycle through the registered tag memory
// read, then walks the slots again to renumber recency; a miss then also
// writes the victim entry. Reset empties the cache, clears the last-used mark
// and the limit. When the receiver stalls, the current result is held and no
// input is taken.
// ---------------------------------------------------------------------------
module cursor_shape_lru_cache (
  input logic clk,
  input logic rst,
  cslru_if.sink   in_ch,
  cslru_if.sink   cfg_ch,
  cslru_if.source out_ch
);
  import cslru_pkg::*;

  logic [LIM_W-1:0] cache_limit;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  out_item_t        res_new, res_cached, res_default;
  logic [1:0]       out_sel;

  // limit register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) cache_limit <= '0;
    else if (cfg_ch.valid) cache_limit <= LIM_W'(cfg_ch.data);
  end

  cslru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_sel   (out_sel),
    .cmd       (cmd),
    .stat      (stat)
  );

  cslru_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (in_ch.data),
    .cache_limit (cache_limit),
    .cmd         (cmd),
    .stat        (stat),
    .res_new     (res_new),
    .res_cached  (res_cached),
    .res_default (res_default)
  );

  // result select
  always_comb begin
    case (out_sel)
      SEL_NEW:    out_ch.data = res_new;
      SEL_CACHED: out_ch.data = res_cached;
      default:    out_ch.data = res_default;
    endcase
  end

endmodule

@@ rtl/cslru_datapath.sv @@
// ---------------------------------------------------------------------------
// cslru_datapath
// Slot store, sequential match/oldest scan and recency update.
// ---------------------------------------------------------------------------
module cslru_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  cslru_pkg::in_item_t     item,
  input  logic [cslru_pkg::LIM_W-1:0] cache_limit,
  input  cslru_pkg::dp_cmd_t      cmd,
  output cslru_pkg::dp_stat_t     stat,
  output cslru_pkg::out_item_t    res_new,
  output cslru_pkg::out_item_t    res_cached,
  output cslru_pkg::out_item_t    res_default
);
  import cslru_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // slot store; key and hotspot held in a memory, valid and recency in flops
  logic [KEY_W+2*HOT_W-1:0] tag_mem [SLOTS];
  logic [SLOTS-1:0]         slot_valid;
  logic [SW-1:0]            slot_recency [SLOTS];
  logic [CW-1:0]            used_count;
  logic                     recent_valid;
  logic [SW-1:0]            recent_slot;

  in_item_t                 cur;
  logic [CW-1:0]            ptr;
  logic [CW-1:0]            ptr_d;
  logic                     rd_live;
  logic [KEY_W+2*HOT_W-1:0] rd_tag;
  logic                     hit;
  logic [SW-1:0]            hit_slot;
  logic [SW-1:0]            best;
  logic [SW-1:0]            old_slot;
  logic                     have_old;
  logic [CW-1:0]            tptr;
  logic [SW-1:0]            tgt;
  logic                     fresh;
  logic [CW-1:0]            lim;
  logic [KEY_W+2*HOT_W-1:0] req_tag;
  logic [SW-1:0]            tref;
  logic [SW-1:0]            vict;
  logic                     vict_fresh;

  assign req_tag = {cur.image_key, cur.hotspot_x, cur.hotspot_y};

  // effective limit
  always_comb begin
    if (cache_limit == '0) lim = CW'(DEFAULT_LIMIT);
    else if ({26'd0, cache_limit} > 32'(SLOTS)) lim = CW'(SLOTS);
    else lim = CW'(cache_limit);
    if (32'(lim) > SLOTS) lim = CW'(SLOTS);
  end

  // victim choice
  always_comb begin
    if (used_count >= lim) begin
      vict       = old_slot;
      vict_fresh = !have_old || !slot_valid[old_slot];
    end else begin
      vict       = SW'(used_count);
      vict_fresh = 1'b1;
    end
  end

  assign tgt   = cmd.sel_new ? vict : hit_slot;
  assign tref  = slot_recency[tgt];

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= item;
  end

  // registered tag read
  always_ff @(posedge clk) begin
    rd_tag <= tag_mem[ptr[SW-1:0]];
    if (cmd.commit) tag_mem[vict] <= req_tag;
  end

  // scan: one slot per cycle, read data registered behind the pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_rst) begin
      ptr      <= '0;
      rd_live  <= 1'b0;
      hit      <= 1'b0;
      hit_slot <= '0;
      best     <= '0;
      old_slot <= '0;
      have_old <= 1'b0;
    end else if (cmd.scan_step) begin
      if (32'(ptr) < SLOTS) ptr <= ptr + 1'b1;
      rd_live <= 32'(ptr) < SLOTS;
      ptr_d   <= ptr;
      if (rd_live) begin
        if (slot_valid[ptr_d[SW-1:0]] && rd_tag == req_tag && !hit) begin
          hit      <= 1'b1;
          hit_slot <= ptr_d[SW-1:0];
        end
        if (slot_valid[ptr_d[SW-1:0]] && slot_recency[ptr_d[SW-1:0]] >= best) begin
          best     <= slot_recency[ptr_d[SW-1:0]];
          old_slot <= ptr_d[SW-1:0];
          have_old <= 1'b1;
        end
      end
    end
  end

  // recency, valid, count and recent mark
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      slot_valid   <= '0;
      used_count   <= '0;
      recent_valid <= 1'b0;
      recent_slot  <= '0;
      tptr         <= '0;
      fresh        <= 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_recency[i] <= '0;
    end else begin
      if (cmd.touch_rst) begin
        tptr  <= '0;
        fresh <= cmd.sel_new ? vict_fresh : 1'b0;
      end else if (cmd.touch_step && 32'(tptr) < SLOTS) begin
        tptr <= tptr + 1'b1;
        if (tptr[SW-1:0] != tgt && slot_valid[tptr[SW-1:0]] &&
            (fresh || slot_recency[tptr[SW-1:0]] < tref))
          slot_recency[tptr[SW-1:0]] <= slot_recency[tptr[SW-1:0]] + 1'b1;
      end
      if (cmd.commit) begin
        slot_recency[tgt] <= '0;
        if (!slot_valid[vict] && 32'(used_count) < SLOTS) used_count <= used_count + 1'b1;
        slot_valid[vict] <= 1'b1;
        recent_valid     <= 1'b1;
        recent_slot      <= vict;
      end
      if (cmd.set_recent) begin
        slot_recency[tgt] <= '0;
        recent_valid      <= 1'b1;
        recent_slot       <= hit_slot;
      end
    end
  end

  // status
  always_comb begin
    stat.is_clear   = cur.opcode == OP_CLEAR;
    stat.is_empty   = cur.img_width == '0 || cur.img_height == '0;
    stat.is_big     = 32'(cur.img_width) > MAX_SIDE || 32'(cur.img_height) > MAX_SIDE;
    stat.recent_hit = recent_valid && hit && hit_slot == recent_slot;
    stat.scan_done  = 32'(ptr) >= SLOTS && !rd_live;
    stat.hit        = hit;
    stat.touch_done = 32'(tptr) >= SLOTS;
  end

  // result formatting; after a miss the committed slot is the recent mark
  always_comb begin
    res_default = '0;
    res_default.kind = KIND_DEFAULT;
    res_default.last = 1'b1;

    res_cached = '0;
    res_cached.kind       = KIND_CACHED;
    res_cached.slot_index = SLOT_W'(hit ? hit_slot : recent_slot);
    res_cached.last       = 1'b1;

    res_new = '0;
    res_new.kind = (32'(cur.img_width) < SMALL_SIDE && 32'(cur.img_height) < SMALL_SIDE)
                   ? KIND_SMALL : KIND_LARGE;
    res_new.slot_index = SLOT_W'(tgt);
    if (cur.hotspot_x < 0) res_new.clamped_hot_x = '0;
    else if (32'(cur.hotspot_x) > 32'(cur.img_width) - 1)
      res_new.clamped_hot_x = CH_W'(cur.img_width - 1'b1);
    else res_new.clamped_hot_x = CH_W'(cur.hotspot_x);
    if (cur.hotspot_y < 0) res_new.clamped_hot_y = '0;
    else if (32'(cur.hotspot_y) > 32'(cur.img_height) - 1)
      res_new.clamped_hot_y = CH_W'(cur.img_height - 1'b1);
    else res_new.clamped_hot_y = CH_W'(cur.hotspot_y);
    res_new.out_width  = CH_W'(cur.img_width);
    res_new.out_height = CH_W'(cur.img_height);
    res_new.last       = 1'b0;
  end

endmodule

@@ rtl/cslru_ctrl.sv @@
// ---------------------------------------------------------------------------
// cslru_ctrl
// Sequencer for one update: scan, touch, commit and result delivery.
// ---------------------------------------------------------------------------
module cslru_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_sel,
  output cslru_pkg::dp_cmd_t   cmd,
  input  cslru_pkg::dp_stat_t  stat
);
  import cslru_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_TOUCH  = 10'b0000001000,
    S_COMMIT = 10'b0000010000,
    S_EMIT1  = 10'b0000100000,
    S_EMIT2  = 10'b0001000000,
    S_BIG    = 10'b0010000000,
    S_HIT    = 10'b0100000000,
    S_SETR   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   is_new, is_new_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      is_new <= 1'b0;
    end else begin
      state  <= state_next;
      is_new <= is_new_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    is_new_next = is_new;
    cmd         = '0;
    cmd.sel_new = is_new;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    out_sel     = SEL_DEFAULT;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.scan_rst = 1'b1;
        if (stat.is_clear) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else if (stat.is_empty) state_next = S_IDLE;
        else if (stat.is_big) state_next = S_BIG;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          is_new_next    = !stat.hit;
          cmd.sel_new    = !stat.hit;
          cmd.touch_rst  = 1'b1;
          state_next     = S_TOUCH;
        end
      end
      S_TOUCH: begin
        cmd.touch_step = 1'b1;
        if (stat.touch_done) begin
          if (is_new) state_next = S_COMMIT;
          else if (stat.recent_hit) state_next = S_SETR;
          else state_next = S_HIT;
        end
      end
      S_SETR: begin
        cmd.set_recent = 1'b1;
        state_next     = S_IDLE;
      end
      S_HIT: begin
        out_valid = 1'b1;
        out_sel   = SEL_CACHED;
        if (out_ready) begin
          cmd.set_recent = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_COMMIT: begin
        out_valid = 1'b1;
        out_sel   = SEL_NEW;
        if (out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_EMIT2;
        end
      end
      S_EMIT1: state_next = S_EMIT2;
      S_EMIT2: begin
        cmd.sel_new = 1'b0;
        out_valid   = 1'b1;
        out_sel     = SEL_CACHED;
        if (out_ready) state_next = S_IDLE;
      end
      S_BIG: begin
        out_valid = 1'b1;
        out_sel   = SEL_DEFAULT;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ tb/tb_cslru_if.sv @@
// ---------------------------------------------------------------------------
// tb_cslru_if
// Testbench-side note: the channel interface comes from the RTL interface
// file; this file holds the scoreboard class used by the testbench top.
// ---------------------------------------------------------------------------
package tb_cslru_sb_pkg;
  import cslru_pkg::*;

  // holds pending pointer commands and the cache shadow state
  class cursor_scoreboard;
    out_item_t  pending[$];
    int         errors;
    logic [5:0] limit_reg;
    bit         ent_valid[32];
    logic [63:0] ent_key[32];
    logic [15:0] ent_hx[32];
    logic [15:0] ent_hy[32];
    int unsigned ent_age[32];
    int unsigned n_used;
    bit          last_valid;
    int unsigned last_slot;

    function new();
      limit_reg = '0;
      wipe();
      errors = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < 32; i++) begin
        ent_valid[i] = 0;
        ent_age[i]   = 0;
      end
      n_used = 0;
      last_valid = 0;
      last_slot = 0;
    endfunction

    function void promote(int unsigned s, bit fresh);
      for (int i = 0; i < 32; i++) begin
        if (i != s && ent_valid[i] && (fresh || ent_age[i] < ent_age[s]))
          ent_age[i] = (ent_age[i] + 1) & 31;
      end
      ent_age[s] = 0;
    endfunction

    function bit same(int unsigned s, in_item_t it);
      return ent_valid[s] && ent_key[s] == it.image_key &&
             ent_hx[s] == it.hotspot_x && ent_hy[s] == it.hotspot_y;
    endfunction

    function logic [8:0] clamp(logic signed [15:0] h, int unsigned side);
      if (h < 0) return 9'd0;
      if (int'(h) > int'(side) - 1) return 9'(side - 1);
      return 9'(h);
    endfunction

    function void push_cmd(kind_t k, int unsigned s, logic [8:0] hx, logic [8:0] hy,
                           logic [8:0] w, logic [8:0] h, logic lst);
      out_item_t o;
      o.kind = k;
      o.slot_index = 5'(s);
      o.clamped_hot_x = hx;
      o.clamped_hot_y = hy;
      o.out_width = w;
      o.out_height = h;
      o.last = lst;
      pending.push_back(o);
    endfunction

    // note an accepted update or clear and queue its pointer commands
    function void note_input(in_item_t it);
      int unsigned w, h, lim, s, best;
      bit fresh;
      w = it.img_width;
      h = it.img_height;
      if (op_t'(it.opcode) == OP_CLEAR) begin
        wipe();
        return;
      end
      if (w == 0 || h == 0) return;
      if (w > 384 || h > 384) begin
        push_cmd(KIND_DEFAULT, 0, 0, 0, 0, 0, 1);
        return;
      end
      if (last_valid && same(last_slot, it)) begin
        promote(last_slot, 0);
        return;
      end
      for (int i = 0; i < 32; i++) begin
        if (same(i, it)) begin
          promote(i, 0);
          last_valid = 1;
          last_slot = i;
          push_cmd(KIND_CACHED, i, 0, 0, 0, 0, 1);
          return;
        end
      end
      lim = limit_reg;
      if (lim == 0) lim = DEFAULT_LIMIT;
      if (lim > 32) lim = 32;
      if (n_used >= lim) begin
        best = 0;
        s = 0;
        for (int i = 0; i < 32; i++) begin
          if (ent_valid[i] && ent_age[i] >= best) begin
            best = ent_age[i];
            s = i;
          end
        end
        fresh = !ent_valid[s];
      end else begin
        s = n_used;
        fresh = 1;
      end
      promote(s, fresh);
      if (fresh && !ent_valid[s] && n_used < 32) n_used++;
      ent_valid[s] = 1;
      ent_key[s] = it.image_key;
      ent_hx[s] = it.hotspot_x;
      ent_hy[s] = it.hotspot_y;
      last_valid = 1;
      last_slot = s;
      push_cmd((w < 96 && h < 96) ? KIND_SMALL : KIND_LARGE, s,
               clamp(it.hotspot_x, w), clamp(it.hotspot_y, h), 9'(w), 9'(h), 0);
      push_cmd(KIND_CACHED, s, 0, 0, 0, 0, 1);
    endfunction

    // compare one accepted pointer command with the oldest pending one
    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected command %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind || got.slot_index !== exp.slot_index ||
          got.clamped_hot_x !== exp.clamped_hot_x ||
          got.clamped_hot_y !== exp.clamped_hot_y ||
          got.out_width !== exp.out_width || got.out_height !== exp.out_height ||
          got.last !== exp.last) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp, got);
        errors++;
      end
    endfunction
  endclass
endpackage

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Cursor-shape cache testbench: directed and random updates checked
// against a behavioural LRU cache predictor under varying back-pressure.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cslru_pkg::*;
  import tb_cslru_sb_pkg::*;

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   snk_stall_pct;
  bit   hold_off;
  int   quiet_cycles;
  cursor_scoreboard sb;

  cslru_if #(.T(in_item_t))   in_ch();
  cslru_if #(.T(logic [5:0])) cfg_ch();
  cslru_if #(.T(out_item_t))  out_ch();

  cursor_shape_lru_cache DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // offer one transaction and wait for acceptance; valid stays up for a
  // following transaction and is dropped by an idle cycle or by drain
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_limit(logic [5:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.limit_reg = v;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic in_item_t mk(op_t op, logic [63:0] k, logic [15:0] hx,
                                  logic [15:0] hy, logic [11:0] w, logic [11:0] h);
    in_item_t it;
    it.opcode = op;
    it.image_key = k;
    it.hotspot_x = hx;
    it.hotspot_y = hy;
    it.img_width = w;
    it.img_height = h;
    return it;
  endfunction

  // random item mostly from a small key pool so hits and evictions happen
  function automatic in_item_t rand_item();
    logic [63:0] k;
    logic [15:0] hx, hy;
    logic [11:0] w, h;
    int r;
    r = $urandom_range(99);
    if (r < 75) begin
      k  = 64'($urandom_range(40)) ^ 64'hA5A5_0000_0000_0000;
      hx = 16'($urandom_range(3)) - 16'd1;
      hy = 16'($urandom_range(1)) * 16'd50;
    end else begin
      k  = {$urandom, $urandom};
      hx = 16'($urandom);
      hy = 16'($urandom);
    end
    r = $urandom_range(99);
    if (r < 4) w = 0;
    else if (r < 10) w = 12'($urandom);
    else if (r < 60) w = 12'($urandom_range(1, 95));
    else w = 12'($urandom_range(96, 384));
    r = $urandom_range(99);
    if (r < 4) h = 0;
    else if (r < 10) h = 12'($urandom);
    else if (r < 60) h = 12'($urandom_range(1, 95));
    else h = 12'($urandom_range(96, 384));
    return mk(($urandom_range(99) < 2) ? OP_CLEAR : OP_UPDATE, k, hx, hy, w, h);
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    repeat (n) send_item(rand_item());
  endtask

  initial begin
    int limits[6];
    sb = new();
    rst = 1'b1;
    hold_off = 0;
    quiet_cycles = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every case
    send_item(mk(OP_UPDATE, 64'h8000_0000_0000_0000, 16'h8000, 16'h7FFF, 12'd1, 12'd1));
    send_item(mk(OP_UPDATE, 64'h8000_0000_0000_0000, 16'h8000, 16'h7FFF, 12'd1, 12'd1));
    send_item(mk(OP_UPDATE, 64'h7FFF_FFFF_FFFF_FFFF, 16'h7FFF, 16'h8000, 12'd384, 12'd384));
    send_item(mk(OP_UPDATE, 64'h8000_0000_0000_0000, 16'h8000, 16'h7FFF, 12'd5, 12'd5));
    send_item(mk(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 12'd95, 12'd96));
    send_item(mk(OP_UPDATE, 64'h0, 16'd0, 16'd0, 12'd0, 12'd10));
    send_item(mk(OP_UPDATE, 64'h0, 16'd0, 16'd0, 12'd10, 12'd0));
    send_item(mk(OP_UPDATE, 64'h0, 16'd0, 16'd0, 12'd385, 12'd1));
    send_item(mk(OP_UPDATE, 64'h0, 16'd0, 16'd0, 12'd1, 12'hFFF));
    send_item(mk(OP_UPDATE, 64'h1, 16'd40, 16'd3, 12'd20, 12'd20));
    send_item(mk(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF));
    send_item(mk(OP_UPDATE, 64'h1, 16'd40, 16'd3, 12'd20, 12'd20));

    // sweep limit settings including extremes and lowering below count
    limits = '{63, 1, 32, 33, 2, 0};
    foreach (limits[i]) begin
      write_limit(6'(limits[i]));
      random_phase(20, 0, 0);
      random_phase(15, 78, 0);
      random_phase(15, 0, 78);
      random_phase(10, 11, 11);
    end

    // long receiver hold-off while the sender keeps offering
    src_idle_pct = 0;
    snk_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      repeat (12) send_item(rand_item());
    join

    // sender pauses until everything has come back
    drain();
    write_limit(6'd4);
    random_phase(40, 0, 0);
    random_phase(30, 11, 11);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/cslru_pkg.sv
rtl/cslru_if.sv
rtl/cslru_datapath.sv
rtl/cslru_ctrl.sv
rtl/cursor_shape_lru_cache.sv
tb/tb_cslru_if.sv
tb/tb.sv
